// ----- sv/pzps_pkg.sv -----
// pzps_pkg: widths, register codes and transaction types shared by the
// zero-prune segmenter front end, queue, back end and top level
// no dependencies
package pzps_pkg;

   localparam int POS_W         = 32;
   localparam int INT_W         = 32;
   localparam int SPIKE_W       = 8;
   localparam int GAP_W         = 4;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 8;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SPIKE_W-1:0] SPIKE_RATIO_RESET = SPIKE_W'(50);
   localparam logic [GAP_W-1:0]   GAP_RATIO_RESET   = GAP_W'(2);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPIKE_STEP_RATIO  = 1'b0,
      CSR_SEGMENT_GAP_RATIO = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PART_FIRST,
      PART_SECOND,
      PART_END
   } part_type;

   typedef struct packed {
      logic [SPIKE_W-1:0] spike_step_ratio;
      logic [GAP_W-1:0]   segment_gap_ratio;
   } cfg_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic [INT_W-1:0] intensity;
   } point_type;

   // work left by one input transaction after zero pruning
   typedef struct packed {
      logic      first_valid;
      point_type first;
      logic      second_valid;
      point_type second;
      logic      scan_end;
      logic      scan_short;
   } bundle_type;

   typedef struct packed {
      point_type point;
      logic      segment_start;
      logic      segment_end;
      logic      scan_error;
   } result_type;

endpackage

// ----- sv/pzps_channels.sv -----
// pzps_req_if and pzps_rsp_if: valid/ready channels for profile points in
// and segmented points out; depends on pzps_pkg
interface pzps_req_if;
   import pzps_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] position;
   logic [INT_W-1:0] intensity;
   logic             scan_last;

   modport source (output valid, output position, output intensity, output scan_last,
                   input ready);
   modport sink   (input valid, input position, input intensity, input scan_last,
                   output ready);
endinterface

interface pzps_rsp_if;
   import pzps_pkg::*;
   logic             valid;
   logic             ready;
   logic [POS_W-1:0] out_position;
   logic [INT_W-1:0] out_intensity;
   logic             segment_start;
   logic             segment_end;
   logic             scan_error;
   logic             run_last;

   modport source (output valid, output out_position, output out_intensity,
                   output segment_start, output segment_end, output scan_error,
                   output run_last, input ready);
   modport sink   (input valid, input out_position, input out_intensity,
                   input segment_start, input segment_end, input scan_error,
                   input run_last, output ready);
endinterface

// ----- sv/pzps_front.sv -----
// pzps_front: accepts profile points, drops zero points between zeros and
// queues the surviving work per transaction; depends on pzps_pkg, pzps_req_if
module pzps_front (
   input  logic                clock,
   input  logic                reset,
   pzps_req_if.sink            req,
   input  logic                queue_full,
   output logic                queue_push,
   output pzps_pkg::bundle_type queue_data
);
   import pzps_pkg::*;

   localparam logic [1:0] RAW_MAX = 2'd3;

   logic [POS_W-1:0] pend_pos_ff, pend_pos_in;
   logic [INT_W-1:0] pend_int_ff, pend_int_in;
   logic             before_zero_ff, before_zero_in;
   logic [1:0]       raw_count_ff, raw_count_in;
   logic             accept;
   logic             cur_zero;
   logic             next_zero;
   logic             short_scan;
   logic             first_keep;
   logic             second_keep;

   assign req.ready = !queue_full;

   always_comb begin
      accept      = req.valid && !queue_full;
      cur_zero    = (pend_int_ff == '0);
      next_zero   = (req.intensity == '0);
      short_scan  = req.scan_last && (raw_count_ff < 2'd2);
      first_keep  = !short_scan && (raw_count_ff != 2'd0)
                    && !(before_zero_ff && cur_zero && next_zero);
      second_keep = req.scan_last && !short_scan && !(cur_zero && next_zero);

      queue_data.first_valid      = first_keep;
      queue_data.first.position   = pend_pos_ff;
      queue_data.first.intensity  = pend_int_ff;
      queue_data.second_valid     = second_keep;
      queue_data.second.position  = req.position;
      queue_data.second.intensity = req.intensity;
      queue_data.scan_end         = req.scan_last;
      queue_data.scan_short       = short_scan;
      queue_push = accept && (first_keep || req.scan_last);

      pend_pos_in    = pend_pos_ff;
      pend_int_in    = pend_int_ff;
      before_zero_in = before_zero_ff;
      raw_count_in   = raw_count_ff;
      if (accept) begin
         if (req.scan_last) begin
            before_zero_in = 1'b1;
            raw_count_in   = '0;
         end else begin
            if (raw_count_ff != 2'd0) begin
               before_zero_in = cur_zero;
            end
            pend_pos_in  = req.position;
            pend_int_in  = req.intensity;
            raw_count_in = (raw_count_ff == RAW_MAX) ? RAW_MAX : raw_count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         before_zero_ff <= 1'b1;
         raw_count_ff   <= '0;
      end else begin
         before_zero_ff <= before_zero_in;
         raw_count_ff   <= raw_count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pos_ff <= pend_pos_in;
      pend_int_ff <= pend_int_in;
   end

endmodule

// ----- sv/pzps_queue.sv -----
// pzps_queue: short transaction queue between front and back end
// depends on pzps_pkg
module pzps_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pzps_pkg::bundle_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output pzps_pkg::bundle_type pop_data
);
   import pzps_pkg::*;

   localparam logic [QUEUE_PTR_W-1:0]   PTR_LAST   = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QUEUE_COUNT_W-1:0] COUNT_FULL = QUEUE_COUNT_W'(QUEUE_DEPTH);
   localparam logic [QUEUE_PTR_W-1:0]   PTR_ONE    = QUEUE_PTR_W'(1);
   localparam logic [QUEUE_COUNT_W-1:0] COUNT_ONE  = QUEUE_COUNT_W'(1);

   bundle_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_W-1:0]   count_ff, count_in;

   always_comb begin
      full      = (count_ff == COUNT_FULL);
      pop_valid = (count_ff != '0);
      pop_data  = slot_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/pzps_back.sv -----
// pzps_back: spike thinning, segment marking and result staging, one point
// per cycle unless the result channel stalls; depends on pzps_pkg, pzps_rsp_if
module pzps_back (
   input  logic                 clock,
   input  logic                 reset,
   input  pzps_pkg::cfg_type    cfg,
   input  logic                 pop_valid,
   input  pzps_pkg::bundle_type pop_data,
   output logic                 pop,
   pzps_rsp_if.source           rsp
);
   import pzps_pkg::*;

   localparam logic [1:0] COUNT_MAX = 2'd2;
   localparam int         SPIKE_PW  = POS_W + SPIKE_W;
   localparam int         GAP_PW    = POS_W + GAP_W;

   logic             first_done_ff, first_done_in;
   logic             second_done_ff, second_done_in;
   logic [POS_W-1:0] thin_last_ff, thin_last_in;
   logic [POS_W-1:0] thin_prior_ff, thin_prior_in;
   logic [1:0]       thin_count_ff, thin_count_in;
   logic [POS_W-1:0] kept_last_ff, kept_last_in;
   logic [POS_W-1:0] kept_prior_ff, kept_prior_in;
   logic [1:0]       kept_count_ff, kept_count_in;
   point_type        held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic             held_opens_ff, held_opens_in;
   result_type       stg_ff, stg_in;
   logic             stg_valid_ff, stg_valid_in;
   logic             stg_done_ff, stg_done_in;
   result_type       out_ff, out_in;
   logic             out_last_ff, out_last_in;
   logic             out_valid_ff, out_valid_in;

   part_type             part;
   logic                 part_last;
   point_type            pt;
   logic                 proceed;
   logic                 out_free;
   logic                 move;
   logic [POS_W-1:0]     thin_step, thin_prev, kept_step, kept_prev;
   logic [SPIKE_PW-1:0]  spike_prod;
   logic [GAP_PW-1:0]    gap_prod;
   logic                 drop;
   logic                 opens;
   logic                 scan_err;
   logic                 res_valid;
   result_type           res;

   always_comb begin
      if (pop_data.first_valid && !first_done_ff) begin
         part      = PART_FIRST;
         part_last = !pop_data.second_valid && !pop_data.scan_end;
      end else if (pop_data.second_valid && !second_done_ff) begin
         part      = PART_SECOND;
         part_last = !pop_data.scan_end;
      end else begin
         part      = PART_END;
         part_last = 1'b1;
      end
      pt = (part == PART_FIRST) ? pop_data.first : pop_data.second;

      out_free = !out_valid_ff || rsp.ready;
      proceed  = pop_valid && (out_free || !stg_valid_ff);
      pop      = proceed && part_last;

      thin_step  = pt.position - thin_last_ff;
      thin_prev  = thin_last_ff - thin_prior_ff;
      kept_step  = pt.position - kept_last_ff;
      kept_prev  = kept_last_ff - kept_prior_ff;
      spike_prod = SPIKE_PW'(thin_step) * SPIKE_PW'(cfg.spike_step_ratio);
      gap_prod   = GAP_PW'(kept_prev) * GAP_PW'(cfg.segment_gap_ratio);
      drop = (thin_count_ff == COUNT_MAX) && (pt.intensity == '0)
             && (spike_prod < SPIKE_PW'(thin_prev));
      if (kept_count_ff == 2'd0) begin
         opens = 1'b1;
      end else if (kept_count_ff == 2'd1) begin
         opens = 1'b0;
      end else begin
         opens = GAP_PW'(kept_step) > gap_prod;
      end
      scan_err = pop_data.scan_short || (thin_count_ff != COUNT_MAX);

      res = '0;
      res_valid = 1'b0;
      case (part)
         PART_FIRST, PART_SECOND: begin
            res_valid         = !drop && held_valid_ff && !(held_opens_ff && opens);
            res.point         = held_ff;
            res.segment_start = held_opens_ff;
            res.segment_end   = opens;
         end
         PART_END: begin
            if (scan_err) begin
               res_valid      = 1'b1;
               res.scan_error = 1'b1;
            end else begin
               res_valid       = held_valid_ff && !held_opens_ff;
               res.point       = held_ff;
               res.segment_end = 1'b1;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase

      // scan state
      first_done_in  = first_done_ff;
      second_done_in = second_done_ff;
      thin_last_in   = thin_last_ff;
      thin_prior_in  = thin_prior_ff;
      thin_count_in  = thin_count_ff;
      kept_last_in   = kept_last_ff;
      kept_prior_in  = kept_prior_ff;
      kept_count_in  = kept_count_ff;
      held_in        = held_ff;
      held_valid_in  = held_valid_ff;
      held_opens_in  = held_opens_ff;
      if (proceed) begin
         if (part_last) begin
            first_done_in  = 1'b0;
            second_done_in = 1'b0;
         end else if (part == PART_FIRST) begin
            first_done_in = 1'b1;
         end else begin
            second_done_in = 1'b1;
         end
         if (part == PART_END) begin
            thin_count_in = '0;
            kept_count_in = '0;
            held_valid_in = 1'b0;
            held_opens_in = 1'b0;
         end else begin
            thin_prior_in = thin_last_ff;
            thin_last_in  = pt.position;
            thin_count_in = (thin_count_ff == COUNT_MAX) ? COUNT_MAX : thin_count_ff + 2'd1;
            if (!drop) begin
               held_in       = pt;
               held_valid_in = 1'b1;
               held_opens_in = opens;
               kept_prior_in = kept_last_ff;
               kept_last_in  = pt.position;
               kept_count_in = (kept_count_ff == COUNT_MAX) ? COUNT_MAX
                               : kept_count_ff + 2'd1;
            end
         end
      end

      // result staging: run_last is known once the next result or the group end shows up
      move = stg_valid_ff && out_free && (stg_done_ff || (proceed && res_valid));

      out_in       = out_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      if (move) begin
         out_in       = stg_ff;
         out_last_in  = stg_done_ff;
         out_valid_in = 1'b1;
      end

      stg_in       = stg_ff;
      stg_valid_in = stg_valid_ff;
      stg_done_in  = stg_done_ff;
      if (proceed && res_valid) begin
         stg_in       = res;
         stg_valid_in = 1'b1;
         stg_done_in  = part_last;
      end else if (move) begin
         stg_valid_in = 1'b0;
      end else if (proceed && part_last && stg_valid_ff) begin
         stg_done_in = 1'b1;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.out_position  = out_ff.point.position;
   assign rsp.out_intensity = out_ff.point.intensity;
   assign rsp.segment_start = out_ff.segment_start;
   assign rsp.segment_end   = out_ff.segment_end;
   assign rsp.scan_error    = out_ff.scan_error;
   assign rsp.run_last      = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_done_ff  <= 1'b0;
         second_done_ff <= 1'b0;
         thin_count_ff  <= '0;
         kept_count_ff  <= '0;
         held_valid_ff  <= 1'b0;
         held_opens_ff  <= 1'b0;
         stg_valid_ff   <= 1'b0;
         stg_done_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         first_done_ff  <= first_done_in;
         second_done_ff <= second_done_in;
         thin_count_ff  <= thin_count_in;
         kept_count_ff  <= kept_count_in;
         held_valid_ff  <= held_valid_in;
         held_opens_ff  <= held_opens_in;
         stg_valid_ff   <= stg_valid_in;
         stg_done_ff    <= stg_done_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      thin_last_ff  <= thin_last_in;
      thin_prior_ff <= thin_prior_in;
      kept_last_ff  <= kept_last_in;
      kept_prior_ff <= kept_prior_in;
      held_ff       <= held_in;
      stg_ff        <= stg_in;
      out_ff        <= out_in;
      out_last_ff   <= out_last_in;
   end

endmodule

// ----- sv/profile_zero_prune_segmenter.sv -----
// Path: a result reaches rsp through the queue and the back end's held, staging and output
// registers; the results of a scan's final point leave one per cycle while rsp is ready.
// Throughput: one point per cycle while the queue is not full; the back end updates spike and
// segment state for one point per cycle unless rsp stalls, and handles a scan's end as its own part.
// Reset: synchronous, active high; clears counters, queue and valid flags and sets the
// ratio registers to 50 and 2. No clearing pass.
module profile_zero_prune_segmenter (
   input  logic                            clock,
   input  logic                            reset,
   pzps_req_if.sink                        req,
   pzps_rsp_if.source                      rsp,
   input  logic                            csr_write_enable,
   input  logic [pzps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pzps_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import pzps_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       queue_push;
   bundle_type queue_wdata;
   logic       queue_full;
   logic       queue_pop;
   logic       queue_valid;
   bundle_type queue_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SPIKE_STEP_RATIO:  cfg_in.spike_step_ratio  = csr_write_data[SPIKE_W-1:0];
            CSR_SEGMENT_GAP_RATIO: cfg_in.segment_gap_ratio = csr_write_data[GAP_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spike_step_ratio  <= SPIKE_RATIO_RESET;
         cfg_ff.segment_gap_ratio <= GAP_RATIO_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pzps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_data (queue_wdata)
   );

   pzps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_wdata),
      .full      (queue_full),
      .pop       (queue_pop),
      .pop_valid (queue_valid),
      .pop_data  (queue_rdata)
   );

   pzps_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (queue_valid),
      .pop_data  (queue_rdata),
      .pop       (queue_pop),
      .rsp       (rsp)
   );

endmodule

// ----- sv/pzps_checker.sv -----
// pzps_checker: port-level assertions on the segmenter result channel
// bound to profile_zero_prune_segmenter; depends on nothing else
module pzps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_position,
   input logic [31:0] rsp_out_intensity,
   input logic        rsp_segment_start,
   input logic        rsp_segment_end,
   input logic        rsp_scan_error,
   input logic        rsp_run_last
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_position)
         && $stable(rsp_out_intensity) && $stable(rsp_segment_start)
         && $stable(rsp_segment_end) && $stable(rsp_scan_error) && $stable(rsp_run_last))
      else $error("result changed while stalled");

   // error result stands alone with empty fields
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scan_error |-> rsp_run_last && !rsp_segment_start
         && !rsp_segment_end && (rsp_out_position == 32'd0) && (rsp_out_intensity == 32'd0))
      else $error("malformed error result");

   // one-point segments never reach the output
   a_no_single_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_segment_start && rsp_segment_end))
      else $error("one-point segment emitted");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind profile_zero_prune_segmenter pzps_checker u_pzps_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_out_position  (rsp.out_position),
   .rsp_out_intensity (rsp.out_intensity),
   .rsp_segment_start (rsp.segment_start),
   .rsp_segment_end   (rsp.segment_end),
   .rsp_scan_error    (rsp.scan_error),
   .rsp_run_last      (rsp.run_last)
);
